>>> hw/rtl/gsm7_text_packer_defines.svh
// ----------------------------------------------------------------------------
// gsm7 text packer assertion macros
// shared property forms for the checker, clocked on clk, muted in reset
// ----------------------------------------------------------------------------
`ifndef GSM7_TEXT_PACKER_DEFINES_SVH
`define GSM7_TEXT_PACKER_DEFINES_SVH

// same-cycle implication
`define GSM7_ASSERT_NOW(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication
`define GSM7_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> hw/rtl/gsm7_pkg.sv
// ----------------------------------------------------------------------------
// gsm7 packer package
// word types, alphabet table and escape codes shared by the packer files
// ----------------------------------------------------------------------------
package gsm7_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int SEPTET_COUNT_W = 16;
  localparam int MAX_OCTETS     = 3;

  localparam logic [6:0] ESC_SEPTET = 7'h1B;
  localparam logic [6:0] CR_SEPTET  = 7'h0D;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0]                octet;
    logic                      is_last_octet;
    logic [SEPTET_COUNT_W-1:0] septet_count;
  } out_word_t;

  // octets produced by one character, lowest entry goes out first
  typedef struct packed {
    logic [MAX_OCTETS-1:0][7:0] octets;
    logic [1:0]                 num;
    logic                       last;
    logic [SEPTET_COUNT_W-1:0]  count;
  } pack_result_t;

  typedef struct packed {
    logic [6:0] pending;
    logic [2:0] fill;
  } pack_state_t;

  localparam logic [7:0] LATIN_TO_SEPTET [0:255] = '{
    8'h1b,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h0a,8'h54,8'h54,8'h0d,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h20,8'h21,8'h22,8'h23,8'h02,8'h25,8'h26,8'h27,
    8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'h2e,8'h2f,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
    8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,
    8'h00,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
    8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,
    8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h54,8'h54,8'h54,8'h54,8'h11,
    8'h54,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
    8'h68,8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,
    8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,
    8'h78,8'h79,8'h7a,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h40,8'h54,8'h01,8'h24,8'h03,8'h54,8'h5f,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,8'h60,
    8'h54,8'h54,8'h54,8'h54,8'h5b,8'h0e,8'h1c,8'h09,
    8'h54,8'h1f,8'h54,8'h54,8'h54,8'h54,8'h54,8'h54,
    8'h54,8'h5d,8'h54,8'h54,8'h54,8'h54,8'h5c,8'h54,
    8'h0b,8'h54,8'h54,8'h54,8'h5e,8'h54,8'h54,8'h1e,
    8'h7f,8'h54,8'h54,8'h54,8'h7b,8'h0f,8'h1d,8'h54,
    8'h04,8'h05,8'h54,8'h54,8'h07,8'h54,8'h54,8'h54,
    8'h54,8'h7d,8'h08,8'h54,8'h54,8'h54,8'h7c,8'h54,
    8'h0c,8'h06,8'h54,8'h54,8'h7e,8'h54,8'h54,8'h54
  };

  // extension code after the escape septet, zero when not escaped
  function automatic logic [6:0] escape_code(input logic [7:0] c);
    logic [6:0] code;
    begin
      case (c)
        8'h5e:   code = 7'h14;
        8'h0c:   code = 7'h0a;
        8'h7c:   code = 7'h40;
        8'h7b:   code = 7'h28;
        8'h7d:   code = 7'h29;
        8'h5b:   code = 7'h3c;
        8'h5d:   code = 7'h3e;
        8'h7e:   code = 7'h3d;
        8'h5c:   code = 7'h2f;
        default: code = 7'h00;
      endcase
      return code;
    end
  endfunction

endpackage

>>> hw/rtl/gsm7_pack_step.sv
// ----------------------------------------------------------------------------
// gsm7 pack step
// maps one character to septets and packs them behind the pending bits
// ----------------------------------------------------------------------------
module gsm7_pack_step #(
  parameter int CountBits = gsm7_pkg::COUNT_BITS_DEF
) (
  input  logic [7:0]              char_byte,
  input  logic                    is_last_char,
  input  logic                    pad_with_cr,
  input  gsm7_pkg::pack_state_t   state,
  input  logic [CountBits-1:0]    total,
  output gsm7_pkg::pack_result_t  result,
  output gsm7_pkg::pack_state_t   state_next,
  output logic [CountBits-1:0]    total_next
);

  logic [6:0]                                code;
  logic                                      esc;
  logic [6:0]                                sept;
  logic [13:0]                               chunk;
  logic [20:0]                               acc;
  logic [20:0]                               shifted;
  logic [4:0]                                nbits;
  logic [1:0]                                nfull;
  logic [2:0]                                rem;
  logic                                      flush;
  logic [CountBits:0]                        sum;
  logic [CountBits-1:0]                      sat;
  logic [CountBits+gsm7_pkg::SEPTET_COUNT_W-1:0] sat_wide;
  logic [gsm7_pkg::MAX_OCTETS-1:0][7:0]      octs;

  assign code  = gsm7_pkg::escape_code(char_byte);
  assign esc   = (code != 7'h00);
  assign sept  = gsm7_pkg::LATIN_TO_SEPTET[char_byte][6:0];
  assign chunk = esc ? {code, gsm7_pkg::ESC_SEPTET} : {7'h00, sept};
  assign acc   = {14'h0000, state.pending} | ({7'h00, chunk} << state.fill);
  assign nbits = {2'b00, state.fill} + (esc ? 5'd14 : 5'd7);
  assign nfull = nbits[4:3];
  assign rem   = nbits[2:0];
  assign flush = is_last_char && (rem != 3'd0);

  assign shifted = acc >> {nfull, 3'b000};

  // saturating septet count, one or two per character
  assign sum      = {1'b0, total} + {{(CountBits-1){1'b0}}, (esc ? 2'd2 : 2'd1)};
  assign sat      = sum[CountBits] ? {CountBits{1'b1}} : sum[CountBits-1:0];
  assign sat_wide = {{gsm7_pkg::SEPTET_COUNT_W{1'b0}}, sat};

  always_comb begin
    octs = {3'b000, acc};
    // cr fill when only one bit of the final octet is used
    if (is_last_char && rem == 3'd1 && pad_with_cr) begin
      octs[nfull] = {gsm7_pkg::CR_SEPTET, octs[nfull][0]};
    end
  end

  assign result.octets = octs;
  assign result.num    = nfull + {1'b0, flush};
  assign result.last   = is_last_char;
  assign result.count  = sat_wide[gsm7_pkg::SEPTET_COUNT_W-1:0];

  assign state_next.pending = is_last_char ? 7'h00 : shifted[6:0];
  assign state_next.fill    = is_last_char ? 3'd0 : rem;
  assign total_next         = is_last_char ? '0 : sat;

endmodule

>>> hw/rtl/gsm7_text_packer.sv
// ----------------------------------------------------------------------------
// gsm7 text packer
// latin-1 characters in, gsm 7-bit default alphabet octets out
// ----------------------------------------------------------------------------
// Takes one Latin-1 character word per cycle unless in_stall holds it
// off, and emits packed GSM 7-bit octets, one output word per cycle while
// out_stall is low. A plain character adds one septet and the nine escaped
// characters add two (escape then extension code), so one character makes
// zero, one or two octets, plus a flush octet on the last character of a
// message when bits are left over. The octet output register is the pacing
// unit: a character holds it until its last octet leaves, while the next
// character waits in the input register; the input stalls when that
// register is full and the output register is not free. Each character
// passes the input register, then the output register. The last octet of a
// message carries the septet count; other octets carry zero there. The
// pad_with_cr setting is written through the cfg port, always ready; the
// user must change it only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module gsm7_text_packer #(
  parameter int CountBits = gsm7_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // character words
  input  logic                in_valid,
  output logic                in_stall,
  input  gsm7_pkg::in_word_t  in_data,
  // octet words
  output logic                out_valid,
  input  logic                out_stall,
  output gsm7_pkg::out_word_t out_data,
  // pad_with_cr register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  // input register
  logic                   s1_valid;
  gsm7_pkg::in_word_t     s1_word;

  // packer state
  logic                   pad_with_cr;
  gsm7_pkg::pack_state_t  state;
  logic [CountBits-1:0]   total;

  // octets of the character in the output stage, entry 0 on the port
  gsm7_pkg::pack_result_t set;

  gsm7_pkg::pack_result_t set_next;
  gsm7_pkg::pack_state_t  state_next;
  logic [CountBits-1:0]   total_next;

  logic pop;
  logic set_free;
  logic load;
  logic accept;

  gsm7_pack_step #(
    .CountBits (CountBits)
  ) u_step (
    .char_byte    (s1_word.char_byte),
    .is_last_char (s1_word.is_last_char),
    .pad_with_cr  (pad_with_cr),
    .state        (state),
    .total        (total),
    .result       (set_next),
    .state_next   (state_next),
    .total_next   (total_next)
  );

  // handshake
  assign out_valid = (set.num != 2'd0);
  assign pop       = out_valid && !out_stall;
  // output stage can take the next character once its last octet leaves
  assign set_free  = (set.num == 2'd0) || (pop && set.num == 2'd1);
  assign load      = s1_valid && set_free;
  assign in_stall  = s1_valid && !set_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // output word, count only shown on the final octet
  assign out_data.octet         = set.octets[0];
  assign out_data.is_last_octet = set.last && (set.num == 2'd1);
  assign out_data.septet_count  = out_data.is_last_octet ? set.count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      pad_with_cr   <= 1'b0;
      state.pending <= 7'h00;
      state.fill    <= 3'd0;
      total         <= '0;
      set.num       <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pad_with_cr <= cfg_data;
      end
      // input register
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (load) begin
        s1_valid <= 1'b0;
      end
      // packer state advances as a character moves into the output stage
      if (load) begin
        state      <= state_next;
        total      <= total_next;
        set.num    <= set_next.num;
        set.octets <= set_next.octets;
        set.last   <= set_next.last;
        set.count  <= set_next.count;
      end else if (pop) begin
        set.num    <= set.num - 2'd1;
        // shift the next octet down to the port
        set.octets <= {8'h00, set.octets[gsm7_pkg::MAX_OCTETS-1:1]};
      end
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= in_data;
    end
  end

endmodule

>>> hw/rtl/gsm7_chk.sv
// ----------------------------------------------------------------------------
// gsm7 packer checker
// port-level properties of the text packer, bound to the top level
// ----------------------------------------------------------------------------
`include "gsm7_text_packer_defines.svh"

module gsm7_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input gsm7_pkg::out_word_t out_data
);

  logic out_wait;
  logic out_mid;
  logic out_last;

  assign out_wait = out_valid && out_stall;
  assign out_mid  = out_valid && !out_data.is_last_octet;
  assign out_last = out_valid && out_data.is_last_octet;

  // a stalled octet stays put
  `GSM7_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "octet moved")

  // count field is zero except on the final octet
  `GSM7_ASSERT_NOW(a_count_last, out_mid, out_data.septet_count == '0, "count on inner octet")

  // input only backs up behind a waiting octet
  `GSM7_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stall with no octet pending")

  // every message holds at least one septet
  `GSM7_ASSERT_NOW(a_last_count, out_last, out_data.septet_count != '0, "final octet count zero")

  // a stalled character word is not withdrawn
  `GSM7_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid, "stalled character dropped")

endmodule

bind gsm7_text_packer gsm7_chk u_gsm7_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
